[hw/rtl/tgbw_pkg.sv]
// shared types, register map and helpers for the tiled grid block walker
`timescale 1ns / 1ps

package tgbw_pkg;

  // limits on the configured block counts and block sizes
  localparam int MAX_TILES     = 64;
  localparam int MAX_TILE_SIZE = 64;

  // field widths
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 6;
  localparam int GIDX_W  = 12;
  localparam int BID_W   = 18;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int OUT_W   = 72;
  localparam int IN_W    = 8;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_TILES_X     = 3'd0;
  localparam logic [2:0] REG_TILES_Y     = 3'd1;
  localparam logic [2:0] REG_TILES_Z     = 3'd2;
  localparam logic [2:0] REG_TILE_SIZE_X = 3'd3;
  localparam logic [2:0] REG_TILE_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_TILE_SIZE_Z = 3'd5;

  // effective walk limits, all in 1..64
  typedef struct packed {
    logic [CFG_W-1:0] tx;
    logic [CFG_W-1:0] ty;
    logic [CFG_W-1:0] tz;
    logic [CFG_W-1:0] sx;
    logic [CFG_W-1:0] sy;
    logic [CFG_W-1:0] sz;
  } limits_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CFG_W-1:0] clamp_limit(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // index is at or past the last value along its axis
  function automatic logic axis_last(input logic [IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] lim);
    return (({1'b0, idx}) + CFG_W'(1)) >= lim;
  endfunction

endpackage

[hw/rtl/tgbw_cfg.sv]
// configuration registers with read-back and clamped walk limits
`timescale 1ns / 1ps

module tgbw_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgbw_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgbw_pkg::DATA_W-1:0]  pwdata,
  output logic [tgbw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tgbw_pkg::limits_t            limits
);
  import tgbw_pkg::*;

  logic [CFG_W-1:0] tiles_x;
  logic [CFG_W-1:0] tiles_y;
  logic [CFG_W-1:0] tiles_z;
  logic [CFG_W-1:0] tile_size_x;
  logic [CFG_W-1:0] tile_size_y;
  logic [CFG_W-1:0] tile_size_z;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic [CFG_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_x     <= CFG_W'(1);
      tiles_y     <= CFG_W'(1);
      tiles_z     <= CFG_W'(1);
      tile_size_x <= CFG_W'(1);
      tile_size_y <= CFG_W'(1);
      tile_size_z <= CFG_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_TILES_X:     tiles_x     <= pwdata[CFG_W-1:0];
        REG_TILES_Y:     tiles_y     <= pwdata[CFG_W-1:0];
        REG_TILES_Z:     tiles_z     <= pwdata[CFG_W-1:0];
        REG_TILE_SIZE_X: tile_size_x <= pwdata[CFG_W-1:0];
        REG_TILE_SIZE_Y: tile_size_y <= pwdata[CFG_W-1:0];
        REG_TILE_SIZE_Z: tile_size_z <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      REG_TILES_X:     rd_val = tiles_x;
      REG_TILES_Y:     rd_val = tiles_y;
      REG_TILES_Z:     rd_val = tiles_z;
      REG_TILE_SIZE_X: rd_val = tile_size_x;
      REG_TILE_SIZE_Y: rd_val = tile_size_y;
      REG_TILE_SIZE_Z: rd_val = tile_size_z;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-CFG_W){1'b0}}, rd_val};

  // effective limits
  assign limits.tx = clamp_limit(tiles_x,     CFG_W'(MAX_TILES));
  assign limits.ty = clamp_limit(tiles_y,     CFG_W'(MAX_TILES));
  assign limits.tz = clamp_limit(tiles_z,     CFG_W'(MAX_TILES));
  assign limits.sx = clamp_limit(tile_size_x, CFG_W'(MAX_TILE_SIZE));
  assign limits.sy = clamp_limit(tile_size_y, CFG_W'(MAX_TILE_SIZE));
  assign limits.sz = clamp_limit(tile_size_z, CFG_W'(MAX_TILE_SIZE));

endmodule

[hw/rtl/tiled_grid_block_walker.sv]
// tiled grid block walker: one grid point per accepted word
// latency: a result word is valid the cycle after its input word is accepted
// throughput: one word per cycle while the output is not stalled; position
// registers step per word, the output register frees as its word is taken
// reset: synchronous, clears the walk position, block number and output valid
// reset: all six limit registers read back as 1
`timescale 1ns / 1ps

module tiled_grid_block_walker (
  input  logic                         clk,
  input  logic                         rst,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgbw_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgbw_pkg::DATA_W-1:0]  pwdata,
  output logic [tgbw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tgbw_pkg::IN_W-1:0]    s_axis_tdata,  // [0] restart, rest zero
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [17:0] block_id, [29:18] gx, [41:30] gy, [53:42] gz,
  // [59:54] lx, [65:60] ly, [71:66] lz
  output logic [tgbw_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tuser,  // [0] end_of_block
  output logic                         m_axis_tlast   // end_of_walk
);
  import tgbw_pkg::*;

  limits_t          limits;

  // walk position: the point the next word emits
  logic [IDX_W-1:0] block_x, block_y, block_z;
  logic [IDX_W-1:0] inner_x, inner_y, inner_z;
  logic [BID_W-1:0] block_counter;

  logic [IDX_W-1:0] block_x_next, block_y_next, block_z_next;
  logic [IDX_W-1:0] inner_x_next, inner_y_next, inner_z_next;
  logic [BID_W-1:0] block_counter_next;

  logic [IDX_W-1:0] cur_bx, cur_by, cur_bz, cur_ix, cur_iy, cur_iz;
  logic [BID_W-1:0] cur_bid;
  logic             restart;
  logic             in_acc;
  logic             w_iz, w_iy, w_ix, w_bz, w_by, w_bx;
  logic             eob, eow;
  logic [12:0]      px, py, pz;
  logic [GIDX_W-1:0] gx, gy, gz;

  tgbw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  assign restart       = s_axis_tdata[0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // position seen by this word, restart starts from the origin
  assign cur_bx  = restart ? '0 : block_x;
  assign cur_by  = restart ? '0 : block_y;
  assign cur_bz  = restart ? '0 : block_z;
  assign cur_ix  = restart ? '0 : inner_x;
  assign cur_iy  = restart ? '0 : inner_y;
  assign cur_iz  = restart ? '0 : inner_z;
  assign cur_bid = restart ? '0 : block_counter;

  // last-along-axis flags
  assign w_iz = axis_last(cur_iz, limits.sz);
  assign w_iy = axis_last(cur_iy, limits.sy);
  assign w_ix = axis_last(cur_ix, limits.sx);
  assign w_bz = axis_last(cur_bz, limits.tz);
  assign w_by = axis_last(cur_by, limits.ty);
  assign w_bx = axis_last(cur_bx, limits.tx);

  assign eob = w_iz && w_iy && w_ix;
  assign eow = eob && w_bz && w_by && w_bx;

  // global indices: block index * tile size + local index
  assign px = {7'd0, cur_bx} * {6'd0, limits.sx};
  assign py = {7'd0, cur_by} * {6'd0, limits.sy};
  assign pz = {7'd0, cur_bz} * {6'd0, limits.sz};
  assign gx = px[GIDX_W-1:0] + {6'd0, cur_ix};
  assign gy = py[GIDX_W-1:0] + {6'd0, cur_iy};
  assign gz = pz[GIDX_W-1:0] + {6'd0, cur_iz};

  // odometer step, z innermost, carries ripple outward
  always_comb begin
    inner_z_next = w_iz ? '0 : cur_iz + IDX_W'(1);
    inner_y_next = cur_iy;
    inner_x_next = cur_ix;
    block_z_next = cur_bz;
    block_y_next = cur_by;
    block_x_next = cur_bx;
    block_counter_next = cur_bid;
    if (w_iz) begin
      inner_y_next = w_iy ? '0 : cur_iy + IDX_W'(1);
    end
    if (w_iz && w_iy) begin
      inner_x_next = w_ix ? '0 : cur_ix + IDX_W'(1);
    end
    if (eob) begin
      block_z_next = w_bz ? '0 : cur_bz + IDX_W'(1);
      block_counter_next = eow ? '0 : cur_bid + BID_W'(1);
    end
    if (eob && w_bz) begin
      block_y_next = w_by ? '0 : cur_by + IDX_W'(1);
    end
    if (eob && w_bz && w_by) begin
      block_x_next = w_bx ? '0 : cur_bx + IDX_W'(1);
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_x       <= '0;
      block_y       <= '0;
      block_z       <= '0;
      inner_x       <= '0;
      inner_y       <= '0;
      inner_z       <= '0;
      block_counter <= '0;
    end else if (in_acc) begin
      block_x       <= block_x_next;
      block_y       <= block_y_next;
      block_z       <= block_z_next;
      inner_x       <= inner_x_next;
      inner_y       <= inner_y_next;
      inner_z       <= inner_z_next;
      block_counter <= block_counter_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_axis_tdata <= {cur_iz, cur_iy, cur_ix, gz, gy, gx, cur_bid};
      m_axis_tuser <= eob;
      m_axis_tlast <= eow;
    end
  end

`ifndef NO_ASSERTIONS
  // end of walk is always also the end of a block
  a_eow_in_eob: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("end of walk without end of block");

  // an accepted word always shows up on the output
  a_acc_valid: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_axis_tvalid)
    else $error("accepted word did not reach the output register");

  // finishing the walk returns the block number to zero
  a_eow_clear: assert property (@(posedge clk) disable iff (rst)
    (in_acc && eow) |=> (block_counter == '0))
    else $error("block number not cleared at end of walk");

  // the block number only moves at a block boundary or restart
  a_bid_hold: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !restart && !eob) |=> $stable(block_counter))
    else $error("block number moved inside a block");
`endif

endmodule
